// File: rtl/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types and constants for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

  // width of the limit registers and the configuration data bus
  localparam int LIMIT_BITS = 10;
  localparam int CFG_IDX_BITS = 1;
  localparam int DELTA_BITS = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_LIMIT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LIMIT = 1'd1;

  // reset values
  localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = 10'd315;
  localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = 10'd235;
  localparam int POS_X_RESET = 160;
  localparam int POS_Y_RESET = 120;

  // header byte bit positions
  localparam int LEFT_POS  = 0;
  localparam int RIGHT_POS = 1;
  localparam int SYNC_POS  = 3;
  localparam int XSIGN_POS = 4;
  localparam int YSIGN_POS = 5;
  localparam int XOVF_POS  = 6;
  localparam int YOVF_POS  = 7;

  // one assembled packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } pkt_t;

endpackage

// File: rtl/mpct_motion.sv
// ----------------------------------------------------------------------------
// mpct_motion
// Decodes packet movement and computes the clamped new cursor position.
// ----------------------------------------------------------------------------
module mpct_motion
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  pkt_t                         pkt,
  input  logic [COORD_BITS-1:0]        pos_x,
  input  logic [COORD_BITS-1:0]        pos_y,
  input  logic [LIMIT_BITS-1:0]        x_limit,
  input  logic [LIMIT_BITS-1:0]        y_limit,
  output logic [COORD_BITS-1:0]        new_x,
  output logic [COORD_BITS-1:0]        new_y,
  output logic signed [DELTA_BITS-1:0] delta_x,
  output logic signed [DELTA_BITS-1:0] delta_y
);

  localparam int WB = COORD_BITS + 2;
  localparam logic [WB-1:0] CMAX = WB'((1 << COORD_BITS) - 1);

  logic signed [WB-1:0] sum_x;
  logic signed [WB-1:0] sum_y;
  logic [WB-1:0]        hi_x;
  logic [WB-1:0]        hi_y;

  // sign-extend movement, zero it on overflow
  assign delta_x = pkt.header[XOVF_POS] ? '0
                 : $signed({pkt.header[XSIGN_POS], pkt.x_move});
  assign delta_y = pkt.header[YOVF_POS] ? '0
                 : $signed({pkt.header[YSIGN_POS], pkt.y_move});

  // limits saturated to the coordinate range
  assign hi_x = (WB'(x_limit) > CMAX) ? CMAX : WB'(x_limit);
  assign hi_y = (WB'(y_limit) > CMAX) ? CMAX : WB'(y_limit);

  // x grows with dx, screen y grows downward
  assign sum_x = $signed({2'b00, pos_x}) + WB'(delta_x);
  assign sum_y = $signed({2'b00, pos_y}) - WB'(delta_y);

  // clamp to 0..limit
  always_comb begin
    if (sum_x[WB-1]) begin
      new_x = '0;
    end else if (unsigned'(sum_x) > hi_x) begin
      new_x = hi_x[COORD_BITS-1:0];
    end else begin
      new_x = sum_x[COORD_BITS-1:0];
    end
    if (sum_y[WB-1]) begin
      new_y = '0;
    end else if (unsigned'(sum_y) > hi_y) begin
      new_y = hi_y[COORD_BITS-1:0];
    end else begin
      new_y = sum_y[COORD_BITS-1:0];
    end
  end

endmodule

// File: rtl/mouse_packet_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker_core
// PS/2 mouse packet decoder driving a clamped cursor position.
// ----------------------------------------------------------------------------
// Takes one received mouse byte per request and groups bytes into 3-byte
// packets; a header byte with bit 3 clear is dropped to regain packet sync.
// On the third byte the cursor moves by +dx / -dy, each coordinate clamped to
// 0..limit (limits saturate to 2^COORD_BITS-1), and one result request with
// position, deltas and buttons is issued. A byte can be accepted in every cycle
// unless the third byte is stalled; the result appears in the output register
// in the cycle after the third byte. Header and X bytes are always
// accepted; a third byte waits only while the output register holds a result
// that is stalled. The limit registers are written through the cfg port.
module mouse_packet_cursor_tracker_core
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [LIMIT_BITS-1:0]        cfg_wdata,
  // byte input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS-1:0]        out_cursor_x,
  output logic [COORD_BITS-1:0]        out_cursor_y,
  output logic signed [DELTA_BITS-1:0] out_delta_x,
  output logic signed [DELTA_BITS-1:0] out_delta_y,
  output logic                         out_left_button,
  output logic                         out_right_button
);

  // byte position within a packet
  localparam logic [1:0] IDX_HDR    = 2'd0;
  localparam logic [1:0] IDX_X      = 2'd1;
  localparam logic [1:0] IDX_Y      = 2'd2;
  localparam logic [1:0] IDX_UNUSED = 2'd3;

  logic [LIMIT_BITS-1:0] x_limit_r;
  logic [LIMIT_BITS-1:0] y_limit_r;
  logic [1:0]            idx_r;
  logic [1:0]            idx_nxt;
  logic [7:0]            header_r;
  logic [7:0]            x_move_r;
  logic [COORD_BITS-1:0] pos_x_r;
  logic [COORD_BITS-1:0] pos_y_r;

  logic                         out_valid_r;
  logic [COORD_BITS-1:0]        cursor_x_r;
  logic [COORD_BITS-1:0]        cursor_y_r;
  logic signed [DELTA_BITS-1:0] delta_x_r;
  logic signed [DELTA_BITS-1:0] delta_y_r;
  logic                         left_r;
  logic                         right_r;

  logic                         in_acc;
  logic                         out_acc;
  logic                         load;
  pkt_t                         pkt;
  logic [COORD_BITS-1:0]        new_x;
  logic [COORD_BITS-1:0]        new_y;
  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;

  // handshakes: only the last packet byte needs room in the output register
  assign in_stall = out_valid_r && out_stall && (idx_r == IDX_Y);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign load     = in_acc && (idx_r == IDX_Y);

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RESET;
      y_limit_r <= Y_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_LIMIT: x_limit_r <= cfg_wdata;
        CFG_Y_LIMIT: y_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // packet byte sequencing, unused index handled as header
  always_comb begin
    case (idx_r)
      IDX_X:   idx_nxt = IDX_Y;
      IDX_Y:   idx_nxt = IDX_HDR;
      default: idx_nxt = in_rx_byte[SYNC_POS] ? IDX_X : IDX_HDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= IDX_HDR;
      header_r <= '0;
      x_move_r <= '0;
    end else if (in_acc) begin
      idx_r <= idx_nxt;
      if (idx_r == IDX_X) begin
        x_move_r <= in_rx_byte;
      end else if ((idx_r != IDX_Y) && in_rx_byte[SYNC_POS]) begin
        header_r <= in_rx_byte;
      end
    end
  end

  // movement decode and clamp
  assign pkt.header = header_r;
  assign pkt.x_move = x_move_r;
  assign pkt.y_move = in_rx_byte;

  mpct_motion #(
    .COORD_BITS (COORD_BITS)
  ) u_motion (
    .pkt     (pkt),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .x_limit (x_limit_r),
    .y_limit (y_limit_r),
    .new_x   (new_x),
    .new_y   (new_y),
    .delta_x (dx),
    .delta_y (dy)
  );

  // cursor position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= COORD_BITS'(POS_X_RESET);
      pos_y_r <= COORD_BITS'(POS_Y_RESET);
    end else if (load) begin
      pos_x_r <= new_x;
      pos_y_r <= new_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cursor_x_r <= new_x;
      cursor_y_r <= new_y;
      delta_x_r  <= dx;
      delta_y_r  <= dy;
      left_r     <= header_r[LEFT_POS];
      right_r    <= header_r[RIGHT_POS];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_x     = cursor_x_r;
  assign out_cursor_y     = cursor_y_r;
  assign out_delta_x      = delta_x_r;
  assign out_delta_y      = delta_y_r;
  assign out_left_button  = left_r;
  assign out_right_button = right_r;

  // checks
  a_third_byte_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (idx_r == IDX_Y)) |=> out_valid_r)
    else $error("third packet byte did not produce a result");

  a_result_from_third: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(idx_r == IDX_Y))
    else $error("result issued outside a third packet byte");

  a_cursor_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ((cursor_x_r == pos_x_r) && (cursor_y_r == pos_y_r)))
    else $error("result cursor differs from stored position");

  a_no_unused_index: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != IDX_UNUSED)
    else $error("byte index reached unused code");

endmodule
